>>> rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared sizes, codes and controller-to-datapath types of the suitor matcher.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int MaxVertices = 1024;
   localparam int MaxEdges    = 16384;
   localparam int VIdxW       = 10;   // vertex index
   localparam int VCntW       = 11;   // vertex count
   localparam int EIdxW       = 14;   // edge index
   localparam int ECntW       = 15;   // edge count
   localparam int WeightW     = 32;

   typedef enum logic [1:0] {
      OP_EDGE  = 2'd0,
      OP_CLOSE = 2'd1,
      OP_RUN   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_VERTICES = 2'd1,
      ST_EDGES    = 2'd2,
      ST_NEIGHBOR = 2'd3
   } status_type;

   typedef enum logic {
      KIND_RUN   = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_EDGE,
      CMD_CLOSE,
      CMD_RUN_INIT,
      CMD_QUERY,
      CMD_CLEAR,
      CMD_TOTAL_RD,
      CMD_TOTAL_SAVE,
      CMD_SCAN_RD,
      CMD_SCAN_CHK,
      CMD_VSTART,
      CMD_LO_RD,
      CMD_HI_RD,
      CMD_HI_SAVE,
      CMD_EDGE_RD,
      CMD_BEST_RD,
      CMD_CMP,
      CMD_SUI_RD,
      CMD_COMMIT,
      CMD_NEXT_V,
      CMD_RUN_DONE,
      CMD_QUERY_DONE
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic clr_last;
      logic stat_nz;
      logic n_zero;
      logic scan_done;
      logic bad_nb;
      logic v_done;
      logic e_done;
      logic heavy_zero;
      logic displaced;
   } dp_stat_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [VIdxW-1:0]   neighbor;
      logic [WeightW-1:0] weight;
      logic [VIdxW-1:0]   query_vertex;
   } req_item_type;

   typedef struct packed {
      logic               kind;
      logic [1:0]         status;
      logic [VCntW-1:0]   vertex_count;
      logic [VIdxW-1:0]   mate;
      logic               has_mate;
   } rsp_item_type;

endpackage

>>> rtl/core/swm_if.sv
// ----------------------------------------------------------------------------
// swm_req_if / swm_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface swm_req_if;
   import swm_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [VIdxW-1:0]   neighbor;
   logic [WeightW-1:0] weight;
   logic [VIdxW-1:0]   query_vertex;
   modport source (output valid, op, neighbor, weight, query_vertex, input ready);
   modport sink   (input valid, op, neighbor, weight, query_vertex, output ready);
endinterface

interface swm_rsp_if;
   import swm_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [1:0]         status;
   logic [VCntW-1:0]   vertex_count;
   logic [VIdxW-1:0]   mate;
   logic               has_mate;
   modport source (output valid, kind, status, vertex_count, mate, has_mate, input ready);
   modport sink   (input valid, kind, status, vertex_count, mate, has_mate, output ready);
endinterface

>>> rtl/core/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer for load, clear, neighbor check, proposal walk and query.
// ----------------------------------------------------------------------------
module swm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_ready,
   input  swm_pkg::dp_stat_type stat,
   output swm_pkg::cmd_type     cmd
);
   import swm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_TOTAL_RD, S_TOTAL_SAVE, S_SCAN, S_SCAN_RD, S_SCAN_CHK,
      S_VERT, S_LO_RD, S_HI_RD, S_HI_SAVE, S_ELOOP, S_EDGE_RD, S_BEST_RD,
      S_CMP, S_DECIDE, S_SUI_RD, S_COMMIT, S_RUN_DONE, S_QUERY
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               case (op_type'(req_op))
                  OP_EDGE:  cmd = CMD_EDGE;
                  OP_CLOSE: cmd = CMD_CLOSE;
                  OP_RUN: begin
                     cmd      = CMD_RUN_INIT;
                     state_in = S_CLEAR;
                  end
                  OP_QUERY: begin
                     cmd      = CMD_QUERY;
                     state_in = S_QUERY;
                  end
                  default: cmd = CMD_NONE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd = CMD_CLEAR;
            if (stat.clr_last) begin
               state_in = (stat.stat_nz || stat.n_zero) ? S_RUN_DONE : S_TOTAL_RD;
            end
         end
         S_TOTAL_RD: begin
            cmd      = CMD_TOTAL_RD;
            state_in = S_TOTAL_SAVE;
         end
         S_TOTAL_SAVE: begin
            cmd      = CMD_TOTAL_SAVE;
            state_in = S_SCAN;
         end
         S_SCAN:     state_in = stat.scan_done ? S_VERT : S_SCAN_RD;
         S_SCAN_RD: begin
            cmd      = CMD_SCAN_RD;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd      = CMD_SCAN_CHK;
            state_in = stat.bad_nb ? S_RUN_DONE : S_SCAN;
         end
         S_VERT: begin
            if (stat.v_done) begin
               state_in = S_RUN_DONE;
            end else begin
               cmd      = CMD_VSTART;
               state_in = S_LO_RD;
            end
         end
         S_LO_RD: begin
            cmd      = CMD_LO_RD;
            state_in = S_HI_RD;
         end
         S_HI_RD: begin
            cmd      = CMD_HI_RD;
            state_in = S_HI_SAVE;
         end
         S_HI_SAVE: begin
            cmd      = CMD_HI_SAVE;
            state_in = S_ELOOP;
         end
         S_ELOOP:    state_in = stat.e_done ? S_DECIDE : S_EDGE_RD;
         S_EDGE_RD: begin
            cmd      = CMD_EDGE_RD;
            state_in = S_BEST_RD;
         end
         S_BEST_RD: begin
            cmd      = CMD_BEST_RD;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd      = CMD_CMP;
            state_in = S_ELOOP;
         end
         S_DECIDE: begin
            if (stat.heavy_zero) begin
               cmd      = CMD_NEXT_V;
               state_in = S_VERT;
            end else begin
               state_in = S_SUI_RD;
            end
         end
         S_SUI_RD: begin
            cmd      = CMD_SUI_RD;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd      = CMD_COMMIT;
            state_in = stat.displaced ? S_LO_RD : S_VERT;
         end
         S_RUN_DONE: begin
            cmd      = CMD_RUN_DONE;
            state_in = S_IDLE;
         end
         S_QUERY: begin
            cmd      = CMD_QUERY_DONE;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/swm_datapath.sv
// ----------------------------------------------------------------------------
// swm_datapath
// Graph stores, offer and suitor stores, walk registers and result register.
// ----------------------------------------------------------------------------
module swm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::cmd_type      cmd,
   input  swm_pkg::req_item_type req,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output swm_pkg::rsp_item_type rsp,
   output swm_pkg::dp_stat_type  stat
);
   import swm_pkg::*;

   // graph stores
   logic [ECntW-1:0]   rowend_mem [MaxVertices];   // row start of vertex + 1
   logic [VIdxW-1:0]   nb_mem     [MaxEdges];
   logic [WeightW-1:0] wt_mem     [MaxEdges];
   logic [WeightW-1:0] best_mem   [MaxVertices];
   logic [VIdxW:0]     sui_mem    [MaxVertices];   // valid bit on top

   logic [ECntW-1:0]   rowend_rd;
   logic [VIdxW-1:0]   nb_rd;
   logic [WeightW-1:0] wt_rd;
   logic [WeightW-1:0] best_rd;
   logic [VIdxW:0]     sui_rd;

   logic [VCntW-1:0]   n_ff;
   logic [ECntW-1:0]   e_ff;
   logic [1:0]         err_ff;
   logic               after_ff;
   logic [1:0]         stat_ff;
   logic [ECntW-1:0]   j_ff, hi_ff, total_ff;
   logic [VCntW-1:0]   v_ff;
   logic [VIdxW-1:0]   cur_ff, partner_ff;
   logic [WeightW-1:0] heavy_ff;
   logic               qok_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;

   logic [VCntW-1:0]   n_e;
   logic [ECntW-1:0]   e_e;
   logic [1:0]         err_e;
   logic               v_full, e_full;
   logic               edge_we, close_we, ob_we;
   logic [VIdxW-1:0]   ob_addr, sui_raddr, row_raddr;
   logic [WeightW-1:0] best_wd;
   logic [VIdxW:0]     sui_wd;
   logic [VCntW-1:0]   n_m1;
   logic               better;

   // a load after a run starts a fresh graph
   assign n_e    = after_ff ? '0 : n_ff;
   assign e_e    = after_ff ? '0 : e_ff;
   assign err_e  = after_ff ? 2'(ST_OK) : err_ff;
   assign v_full = n_e >= VCntW'(MaxVertices);
   assign e_full = e_e >= ECntW'(MaxEdges);
   assign n_m1   = n_ff - VCntW'(1);

   assign edge_we  = (cmd == CMD_EDGE) && !v_full && !e_full;
   assign close_we = (cmd == CMD_CLOSE) && !v_full;
   assign ob_we    = (cmd == CMD_CLEAR) || (cmd == CMD_COMMIT);
   assign ob_addr  = (cmd == CMD_CLEAR) ? j_ff[VIdxW-1:0] : partner_ff;
   assign best_wd  = (cmd == CMD_CLEAR) ? '0 : heavy_ff;
   assign sui_wd   = (cmd == CMD_CLEAR) ? '0 : {1'b1, cur_ff};
   assign sui_raddr = (cmd == CMD_QUERY) ? req.query_vertex : partner_ff;
   assign better   = (wt_rd > heavy_ff) && (best_rd < wt_rd);

   always_comb begin
      case (cmd)
         CMD_TOTAL_RD: row_raddr = n_m1[VIdxW-1:0];
         CMD_LO_RD:    row_raddr = cur_ff - VIdxW'(1);
         default:      row_raddr = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (close_we) begin
         rowend_mem[n_e[VIdxW-1:0]] <= e_e;
      end
      rowend_rd <= rowend_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         nb_mem[e_e[EIdxW-1:0]] <= req.neighbor;
         wt_mem[e_e[EIdxW-1:0]] <= req.weight;
      end
      nb_rd <= nb_mem[j_ff[EIdxW-1:0]];
      wt_rd <= wt_mem[j_ff[EIdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ob_we) begin
         best_mem[ob_addr] <= best_wd;
      end
      best_rd <= best_mem[nb_rd];
   end

   always_ff @(posedge clock) begin
      if (ob_we) begin
         sui_mem[ob_addr] <= sui_wd;
      end
      sui_rd <= sui_mem[sui_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         e_ff         <= '0;
         err_ff       <= ST_OK;
         after_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd)
            CMD_EDGE: begin
               after_ff <= 1'b0;
               n_ff     <= n_e;
               e_ff     <= edge_we ? e_e + ECntW'(1) : e_e;
               // first error kept
               if (err_e != ST_OK) begin
                  err_ff <= err_e;
               end else if (v_full) begin
                  err_ff <= ST_VERTICES;
               end else if (e_full) begin
                  err_ff <= ST_EDGES;
               end else begin
                  err_ff <= ST_OK;
               end
            end
            CMD_CLOSE: begin
               after_ff <= 1'b0;
               e_ff     <= e_e;
               n_ff     <= close_we ? n_e + VCntW'(1) : n_e;
               err_ff   <= (err_e == ST_OK && v_full) ? 2'(ST_VERTICES) : err_e;
            end
            CMD_RUN_DONE: begin
               after_ff            <= 1'b1;
               rsp_valid_ff        <= 1'b1;
               rsp_ff.kind         <= KIND_RUN;
               rsp_ff.status       <= stat_ff;
               rsp_ff.vertex_count <= n_ff;
               rsp_ff.mate         <= '0;
               rsp_ff.has_mate     <= 1'b0;
            end
            CMD_QUERY_DONE: begin
               rsp_valid_ff        <= 1'b1;
               rsp_ff.kind         <= KIND_QUERY;
               rsp_ff.status       <= ST_OK;
               rsp_ff.vertex_count <= n_ff;
               rsp_ff.has_mate     <= qok_ff && sui_rd[VIdxW];
               rsp_ff.mate         <= (qok_ff && sui_rd[VIdxW]) ? sui_rd[VIdxW-1:0] : '0;
            end
            default: ;
         endcase
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_QUERY:      qok_ff <= after_ff && ({1'b0, req.query_vertex} < n_ff);
         CMD_RUN_INIT: begin
            j_ff    <= '0;
            stat_ff <= err_ff;
            v_ff    <= '0;
         end
         CMD_CLEAR:      j_ff <= j_ff + ECntW'(1);
         CMD_TOTAL_RD:   j_ff <= '0;
         CMD_TOTAL_SAVE: total_ff <= rowend_rd;
         CMD_SCAN_CHK: begin
            j_ff <= j_ff + ECntW'(1);
            if ({1'b0, nb_rd} >= n_ff) begin
               stat_ff <= ST_NEIGHBOR;
            end
         end
         CMD_VSTART:     cur_ff <= v_ff[VIdxW-1:0];
         CMD_HI_RD:      j_ff <= (cur_ff == '0) ? '0 : rowend_rd;
         CMD_HI_SAVE: begin
            hi_ff      <= rowend_rd;
            heavy_ff   <= '0;
            partner_ff <= '0;
         end
         CMD_CMP: begin
            j_ff <= j_ff + ECntW'(1);
            if (better) begin
               heavy_ff   <= wt_rd;
               partner_ff <= nb_rd;
            end
         end
         CMD_COMMIT: begin
            if (sui_rd[VIdxW]) begin
               cur_ff <= sui_rd[VIdxW-1:0];
            end else begin
               v_ff <= v_ff + VCntW'(1);
            end
         end
         CMD_NEXT_V:     v_ff <= v_ff + VCntW'(1);
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp            = rsp_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.clr_last   = &j_ff[VIdxW-1:0];
   assign stat.stat_nz    = stat_ff != ST_OK;
   assign stat.n_zero     = n_ff == '0;
   assign stat.scan_done  = j_ff >= total_ff;
   assign stat.bad_nb     = {1'b0, nb_rd} >= n_ff;
   assign stat.v_done     = v_ff >= n_ff;
   assign stat.e_done     = j_ff >= hi_ff;
   assign stat.heavy_zero = heavy_ff == '0;
   assign stat.displaced  = sui_rd[VIdxW];

endmodule

>>> rtl/core/suitor_weighted_matching.sv
// ----------------------------------------------------------------------------
// suitor_weighted_matching
// Half-approximate weighted matching by the serial suitor rule.
// ----------------------------------------------------------------------------
// one item at a time; edge and close beats are handled in the idle state. a
// run first sweeps all 1024 offer and suitor entries back to zero, checks
// every stored neighbor against the vertex count, then walks each proposal
// (including repeat proposals of displaced suitors) one edge at a time, as
// the edge and offer stores each have a single read port. a query reads the
// suitor store, then writes its answer. results sit in an output register, so
// a new beat is taken as soon as that register is empty or being drained.
module suitor_weighted_matching (
   input  logic clock,
   input  logic reset,
   swm_req_if.sink   req_ch,
   swm_rsp_if.source rsp_ch
);
   import swm_pkg::*;

   cmd_type      cmd;        // one datapath step per cycle
   dp_stat_type  stat;       // loop ends and compare flags back to the sequencer
   req_item_type req_item;
   rsp_item_type rsp_item;

   // unpack the request beat
   assign req_item.op           = req_ch.op;
   assign req_item.neighbor     = req_ch.neighbor;
   assign req_item.weight       = req_ch.weight;
   assign req_item.query_vertex = req_ch.query_vertex;

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swm_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_item),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp       (rsp_item),
      .stat      (stat)
   );

   // result beat fields
   assign rsp_ch.kind         = rsp_item.kind;
   assign rsp_ch.status       = rsp_item.status;
   assign rsp_ch.vertex_count = rsp_item.vertex_count;
   assign rsp_ch.mate         = rsp_item.mate;
   assign rsp_ch.has_mate     = rsp_item.has_mate;

endmodule

>>> rtl/core/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_kind,
   input logic [1:0]                rsp_status,
   input logic [swm_pkg::VIdxW-1:0] rsp_mate,
   input logic                      rsp_has_mate
);
   import swm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   a_run_no_mate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RUN |-> !rsp_has_mate && rsp_mate == '0)
      else $error("run result carries a mate");

   a_query_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_QUERY |->
         rsp_status == ST_OK && (rsp_has_mate || rsp_mate == '0))
      else $error("bad query answer fields");

endmodule

bind suitor_weighted_matching swm_checker u_swm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_status   (rsp_ch.status),
   .rsp_mate     (rsp_ch.mate),
   .rsp_has_mate (rsp_ch.has_mate)
);
